/* hw/rtl/pid_pkg.sv */
package pid_pkg;

  // register indexes (word address = 4 * index)
  localparam int CFG_AW = 5;
  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_KP        = 3'd1;
  localparam logic [2:0] REG_KI        = 3'd2;
  localparam logic [2:0] REG_KD        = 3'd3;
  localparam logic [2:0] REG_MAX_OUT   = 3'd4;
  localparam logic [2:0] REG_INT_LIMIT = 3'd5;

  localparam logic MODE_POS  = 1'b0;
  localparam logic MODE_INC  = 1'b1;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic signed [31:0] INT32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic        mode;
    logic [31:0] kp;
    logic [31:0] ki;
    logic [31:0] kd;
    logic [30:0] max_out;
    logic [30:0] int_limit;
  } cfg_t;

  // saturated gain products of one item
  typedef struct packed {
    logic        clr;
    logic [31:0] p;
    logic [31:0] i;
    logic [31:0] d;
  } prod_t;

  // clamp a wide sum to +-lim
  function automatic logic signed [31:0] clamp_mag(input logic signed [33:0] v,
                                                   input logic [30:0] lim);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = $signed({3'b000, lim});
    lo = -hi;
    if (v > hi) begin
      return hi[31:0];
    end else if (v < lo) begin
      return lo[31:0];
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

/* hw/rtl/pid_cfg_regs.sv */
module pid_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [pid_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready,
  output pid_pkg::cfg_t             cfg
);

  pid_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [2:0]    idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx        = cfg_paddr[4:2];
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        pid_pkg::REG_MODE:      cfg_r.mode      <= cfg_pwdata[0];
        pid_pkg::REG_KP:        cfg_r.kp        <= cfg_pwdata;
        pid_pkg::REG_KI:        cfg_r.ki        <= cfg_pwdata;
        pid_pkg::REG_KD:        cfg_r.kd        <= cfg_pwdata;
        pid_pkg::REG_MAX_OUT:   cfg_r.max_out   <= cfg_pwdata[30:0];
        pid_pkg::REG_INT_LIMIT: cfg_r.int_limit <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pid_pkg::REG_MODE:      cfg_prdata = {31'd0, cfg_r.mode};
      pid_pkg::REG_KP:        cfg_prdata = cfg_r.kp;
      pid_pkg::REG_KI:        cfg_prdata = cfg_r.ki;
      pid_pkg::REG_KD:        cfg_prdata = cfg_r.kd;
      pid_pkg::REG_MAX_OUT:   cfg_prdata = {1'b0, cfg_r.max_out};
      pid_pkg::REG_INT_LIMIT: cfg_prdata = {1'b0, cfg_r.int_limit};
      default:                cfg_prdata = 32'd0;
    endcase
  end

endmodule

/* hw/rtl/pid_prod_stage.sv */
module pid_prod_stage #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pid_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic signed [SAMPLE_BITS-1:0] in_meas,
  input  logic signed [SAMPLE_BITS-1:0] in_setp,
  output logic                          o_vld,
  input  logic                          o_ready,
  output pid_pkg::prod_t                o_prod
);

  localparam int ERRW = SAMPLE_BITS + 1;
  localparam int OPW  = SAMPLE_BITS + 3;
  localparam int PW   = 32 + OPW;
  localparam logic signed [PW-1:0] SMAX = PW'(pid_pkg::INT32_MAX);
  localparam logic signed [PW-1:0] SMIN = PW'(pid_pkg::INT32_MIN);

  // input register
  logic                          a_vld_r;
  logic                          a_cmd_r;
  logic signed [SAMPLE_BITS-1:0] a_m_r;
  logic signed [SAMPLE_BITS-1:0] a_sp_r;

  // history of accepted samples
  logic signed [ERRW-1:0]        last_err_r;
  logic signed [SAMPLE_BITS-1:0] pm0_r;
  logic signed [SAMPLE_BITS-1:0] pm1_r;

  logic           b_vld_r;
  pid_pkg::prod_t b_r;

  logic b_free, a_adv, a_free;
  logic signed [OPW-1:0] err, op_p, op_d;
  logic signed [PW-1:0]  prod_p, prod_i, prod_d;
  pid_pkg::prod_t        b_nxt;

  function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
    if (v > SMAX) begin
      return pid_pkg::INT32_MAX;
    end else if (v < SMIN) begin
      return pid_pkg::INT32_MIN;
    end else begin
      return v[31:0];
    end
  endfunction

  assign b_free   = !b_vld_r || o_ready;
  assign a_adv    = a_vld_r && b_free;
  assign a_free   = !a_vld_r || b_free;
  assign in_ready = a_free;

  always_comb begin
    err = OPW'(a_sp_r) - OPW'(a_m_r);
    if (cfg.mode == pid_pkg::MODE_INC) begin
      op_p = err - OPW'(last_err_r);
      op_d = OPW'(pm1_r) - (OPW'(pm0_r) <<< 1) + OPW'(a_m_r);
    end else begin
      op_p = err;
      op_d = OPW'(pm0_r) - OPW'(a_m_r);
    end
    prod_p = PW'($signed(cfg.kp)) * PW'(op_p);
    prod_i = PW'($signed(cfg.ki)) * PW'(err);
    prod_d = PW'($signed(cfg.kd)) * PW'(op_d);
    b_nxt.clr = (a_cmd_r == pid_pkg::CMD_CLEAR);
    b_nxt.p   = sat32(prod_p);
    b_nxt.i   = sat32(prod_i);
    b_nxt.d   = sat32(prod_d);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      a_vld_r <= 1'b1;
    end else if (a_adv) begin
      a_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_cmd_r <= in_cmd;
      a_m_r   <= in_meas;
      a_sp_r  <= in_setp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
      pm0_r      <= '0;
      pm1_r      <= '0;
    end else if (a_adv) begin
      if (a_cmd_r == pid_pkg::CMD_CLEAR) begin
        last_err_r <= '0;
        pm0_r      <= '0;
        pm1_r      <= '0;
      end else begin
        last_err_r <= err[ERRW-1:0];
        pm0_r      <= a_m_r;
        pm1_r      <= pm0_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (a_adv) begin
      b_vld_r <= 1'b1;
    end else if (b_free) begin
      b_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_r <= b_nxt;
    end
  end

  assign o_vld  = b_vld_r;
  assign o_prod = b_r;

endmodule

/* hw/rtl/pid_accum_stage.sv */
module pid_accum_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  pid_pkg::cfg_t      cfg,
  input  logic               in_vld,
  output logic               in_ready,
  input  pid_pkg::prod_t     prod,
  output logic               out_vld,
  input  logic               out_ready,
  output logic signed [31:0] drive,
  output logic signed [31:0] integral
);

  logic               out_vld_r;
  logic signed [31:0] integral_r;
  logic signed [31:0] last_drive_r;   // doubles as the output data register

  logic               adv;
  logic signed [33:0] i_sum, d_sum;
  logic signed [31:0] i_clamp, i_term, integral_nxt, drive_nxt;

  assign in_ready = !out_vld_r || out_ready;
  assign adv      = in_vld && in_ready;

  always_comb begin
    i_sum   = 34'(integral_r) + 34'($signed(prod.i));
    i_clamp = pid_pkg::clamp_mag(i_sum, cfg.int_limit);
    if (cfg.mode == pid_pkg::MODE_INC) begin
      i_term = $signed(prod.i);
      d_sum  = 34'(last_drive_r) + 34'($signed(prod.p)) + 34'(i_term)
             + 34'($signed(prod.d));
    end else begin
      i_term = i_clamp;
      d_sum  = 34'($signed(prod.p)) + 34'(i_term) + 34'($signed(prod.d));
    end
    if (prod.clr) begin
      integral_nxt = '0;
      drive_nxt    = '0;
    end else begin
      integral_nxt = i_term;
      drive_nxt    = pid_pkg::clamp_mag(d_sum, cfg.max_out);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r    <= 1'b0;
      integral_r   <= '0;
      last_drive_r <= '0;
    end else begin
      if (adv) begin
        out_vld_r    <= 1'b1;
        integral_r   <= integral_nxt;
        last_drive_r <= drive_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_vld  = out_vld_r;
  assign drive    = last_drive_r;
  assign integral = integral_r;

endmodule

/* hw/rtl/pid_position_or_incremental_core.sv */
// PID controller, position or incremental form, signed Q16.16 gains, unsigned Q16.16 limits.
// Input stream: in_tuser = command (1 clears all history and returns a zero
// drive, 0 runs one control step), in_tdata = measured and setpoint samples.
// Output stream: out_tdata = clamped drive, one item per input item, in order.
// Gains, limits and mode are set over the APB-style cfg_ port (word offsets
// 0x00 mode, 0x04 kp, 0x08 ki, 0x0C kd, 0x10 max_out, 0x14 int_limit); change
// them only while no item is in flight.
// From input accept to out_tvalid an item passes the input register, the
// gain-product register and the output register, which takes the
// integral/drive add and clamp. One item per cycle is sustained while
// out_tready stays high; the history loop closes within the product stage and
// the integral and last-drive accumulate loop closes within the last stage.
// Reset (synchronous, rst_n low) zeroes registers, history, integral and drive
// and empties the pipeline. When out_tready is low the result holds and the
// stages behind it keep filling; in_tready drops once all three are full.
module pid_position_or_incremental_core #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // [SAMPLE_BITS-1:0] measured, [2*SAMPLE_BITS-1:SAMPLE_BITS] setpoint, zero pad
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  // [0] command
  input  logic                       in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [31:0] drive
  output logic [31:0]                out_tdata,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [pid_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  pid_pkg::cfg_t      cfg;
  logic               prod_vld;
  logic               acc_ready;
  pid_pkg::prod_t     prod;
  logic signed [31:0] drive;
  logic signed [31:0] integral;
  logic signed [31:0] lim_out_s;
  logic signed [31:0] lim_int_s;
  logic               acc_adv;

  pid_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  pid_prod_stage #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_prod (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (in_tuser),
    .in_meas  ($signed(in_tdata[SAMPLE_BITS-1:0])),
    .in_setp  ($signed(in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
    .o_vld    (prod_vld),
    .o_ready  (acc_ready),
    .o_prod   (prod)
  );

  pid_accum_stage u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_vld    (prod_vld),
    .in_ready  (acc_ready),
    .prod      (prod),
    .out_vld   (out_tvalid),
    .out_ready (out_tready),
    .drive     (drive),
    .integral  (integral)
  );

  assign out_tdata = drive;
  assign lim_out_s = $signed({1'b0, cfg.max_out});
  assign lim_int_s = $signed({1'b0, cfg.int_limit});
  assign acc_adv   = prod_vld && acc_ready;

  a_adv_valid: assert property (@(posedge clk) disable iff (!rst_n)
    acc_adv |=> out_tvalid)
    else $error("result register not loaded after accept");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_adv && prod.clr) |=> (drive == 32'sd0 && integral == 32'sd0))
    else $error("clear did not zero drive and integral");

  a_drive_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_adv && !prod.clr) |=>
      (drive <= $past(lim_out_s) && drive >= -$past(lim_out_s)))
    else $error("drive outside max_out");

  a_int_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_adv && !prod.clr && cfg.mode == pid_pkg::MODE_POS) |=>
      (integral <= $past(lim_int_s) && integral >= -$past(lim_int_s)))
    else $error("integral outside its limit in position mode");

endmodule

/* bench/tb_top.sv */
module tb_top;

  localparam int PIPE_DEPTH  = 3;
  localparam int QUIET_LIMIT = 4000;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 153;
  localparam int ROWS        = 22;
  localparam logic       CMD_CLR  = pid_pkg::CMD_CLEAR;
  localparam logic       CMD_STEP = ~pid_pkg::CMD_CLEAR;
  localparam logic [2:0] REG_NONE = 3'd6;  // first index past the register list

  typedef struct packed {
    logic [2:0]  ph;
    logic        cmd;
    logic [15:0] meas;
    logic [15:0] sp;
    logic        fixed;
    logic [31:0] drv;
  } script_row_t;

  typedef struct {
    logic   mode;
    longint kp;
    longint ki;
    longint kd;
    longint lim_out;
    longint lim_int;
  } gains_t;

  typedef struct {
    longint err1;
    longint m1;
    longint m2;
    longint integ;
    longint drv1;
  } loop_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;  // [15:0] measured, [31:16] setpoint
  logic        in_tuser = 1'b0;  // [0] command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;  // [31:0] drive
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [pid_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  gains_t      ctl;
  loop_state_t hist;
  logic [31:0] drive_q[$];
  logic [31:0] drive_want;
  int          misses = 0;
  int          quiet = 0;
  int          burst_left = 0;
  int          rx_hold = 0;
  int          rx_style = 0;
  logic [7:0]  rx_age = '0;

  script_row_t script [ROWS] = '{
    '{3'd0, CMD_STEP, 16'h8000, 16'h7fff, 1'b1, 32'h0},
    '{3'd0, CMD_STEP, 16'h7fff, 16'h8000, 1'b1, 32'h0},
    '{3'd0, CMD_CLR,  16'hffff, 16'hffff, 1'b1, 32'h0},
    '{3'd1, CMD_STEP, 16'h8000, 16'h7fff, 1'b0, 32'h0},
    '{3'd1, CMD_STEP, 16'h7fff, 16'h8000, 1'b0, 32'h0},
    '{3'd1, CMD_STEP, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{3'd1, CMD_STEP, 16'h0064, 16'h0065, 1'b0, 32'h0},
    '{3'd1, CMD_CLR,  16'h1234, 16'h5678, 1'b1, 32'h0},
    '{3'd1, CMD_STEP, 16'hffff, 16'h0001, 1'b0, 32'h0},
    '{3'd2, CMD_STEP, 16'h7fff, 16'h8000, 1'b0, 32'h0},
    '{3'd2, CMD_STEP, 16'h8000, 16'h7fff, 1'b0, 32'h0},
    '{3'd2, CMD_STEP, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{3'd2, CMD_STEP, 16'h0005, 16'hfffd, 1'b0, 32'h0},
    '{3'd2, CMD_STEP, 16'h0005, 16'hfffd, 1'b0, 32'h0},
    '{3'd2, CMD_STEP, 16'hfff9, 16'h000a, 1'b0, 32'h0},
    '{3'd3, CMD_STEP, 16'h000c, 16'h0028, 1'b1, 32'h0},
    '{3'd3, CMD_STEP, 16'h8000, 16'h7fff, 1'b1, 32'h0},
    '{3'd4, CMD_STEP, 16'h03e8, 16'hfc18, 1'b0, 32'h0},
    '{3'd4, CMD_STEP, 16'h03e8, 16'hfc18, 1'b0, 32'h0},
    '{3'd4, CMD_STEP, 16'hfffb, 16'h0014, 1'b0, 32'h0},
    '{3'd4, CMD_CLR,  16'haaaa, 16'h5555, 1'b1, 32'h0},
    '{3'd4, CMD_STEP, 16'h0003, 16'h0009, 1'b0, 32'h0}
  };

  pid_position_or_incremental_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint limit_mag(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // one control step on the local copy of the loop state
  function automatic logic [31:0] next_drive(logic cmd, logic [15:0] mraw, logic [15:0] spraw);
    longint m;
    longint e;
    longint p;
    longint i;
    longint d;
    longint drv;
    if (cmd == pid_pkg::CMD_CLEAR) begin
      hist = '{default: 0};
      return 32'h0;
    end
    m = longint'($signed(mraw));
    e = longint'($signed(spraw)) - m;
    if (ctl.mode == pid_pkg::MODE_POS) begin
      p = sat_word(ctl.kp * e);
      i = limit_mag(hist.integ + sat_word(ctl.ki * e), ctl.lim_int);
      d = sat_word(ctl.kd * (hist.m1 - m));
      drv = p + i + d;
    end else begin
      p = sat_word(ctl.kp * (e - hist.err1));
      i = sat_word(ctl.ki * e);
      d = sat_word(ctl.kd * (hist.m2 - 2 * hist.m1 + m));
      drv = hist.drv1 + p + i + d;
    end
    drv = limit_mag(drv, ctl.lim_out);
    hist.integ = i;
    hist.err1 = e;
    hist.m2 = hist.m1;
    hist.m1 = m;
    hist.drv1 = drv;
    return drv[31:0];
  endfunction

  task automatic put_reg(logic [2:0] idx, logic [31:0] v);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      pid_pkg::REG_MODE:      ctl.mode = v[0];
      pid_pkg::REG_KP:        ctl.kp = longint'($signed(v));
      pid_pkg::REG_KI:        ctl.ki = longint'($signed(v));
      pid_pkg::REG_KD:        ctl.kd = longint'($signed(v));
      pid_pkg::REG_MAX_OUT:   ctl.lim_out = longint'(v[30:0]);
      pid_pkg::REG_INT_LIMIT: ctl.lim_int = longint'(v[30:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_cfg(logic [31:0] md, logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                          logic [31:0] lo, logic [31:0] li);
    put_reg(pid_pkg::REG_MODE, md);
    put_reg(pid_pkg::REG_KP, kp);
    put_reg(pid_pkg::REG_KI, ki);
    put_reg(pid_pkg::REG_KD, kd);
    put_reg(pid_pkg::REG_MAX_OUT, lo);
    put_reg(pid_pkg::REG_INT_LIMIT, li);
    put_reg(REG_NONE, $urandom);  // must be ignored
  endtask

  task automatic dir_cfg(logic [2:0] ph);
    case (ph)
      3'd1: load_cfg(32'(pid_pkg::MODE_POS), pid_pkg::INT32_MAX, pid_pkg::INT32_MAX,
                     pid_pkg::INT32_MIN, 32'hffff_ffff, 32'h7fff_ffff);
      3'd2: load_cfg(32'(pid_pkg::MODE_INC), pid_pkg::INT32_MIN, 32'h0001_0000,
                     pid_pkg::INT32_MAX, 32'h0100_0000, 32'h0);
      // zero output limit; integral from the incremental steps carries over
      3'd3: load_cfg(32'(pid_pkg::MODE_POS), 32'h0001_0000, 32'h0000_8000, 32'hffff_0000,
                     32'h0, 32'h7fff_ffff);
      3'd4: load_cfg(32'(pid_pkg::MODE_POS), 32'h0001_0000, 32'h0000_8000, 32'hffff_0000,
                     32'h7fff_ffff, 32'h0020_0000);
      default: ;  // reset values
    endcase
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return pid_pkg::INT32_MAX;
      1: return pid_pkg::INT32_MIN;
      2: return 32'h0;
      3: return $urandom;
      default: return 32'($urandom_range(0, 32'h60000)) - 32'h30000;
    endcase
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 4))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return $urandom;
      default: return 32'($urandom_range(0, 32'h0040_0000));
    endcase
  endfunction

  // drop valid and let the pipeline drain before touching registers
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (drive_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic send(logic cmd, logic [15:0] meas, logic [15:0] sp, logic fixed,
                      logic [31:0] drv);
    logic [31:0] guess;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {sp, meas};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    guess = next_drive(cmd, meas, sp);
    drive_q.push_back(fixed ? drv : guess);
  endtask

  task automatic flag_miss(logic orphan, logic [31:0] want, logic [31:0] got);
    misses++;
    if (misses <= 10) begin
      if (orphan) $display("mismatch: drive %h with no item pending", got);
      else $display("mismatch: drive expected %h got %h", want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (drive_q.size() == 0) begin
        flag_miss(1'b1, '0, out_tdata);
      end else begin
        drive_want = drive_q.pop_front();
        if (drive_want !== out_tdata) flag_miss(1'b0, drive_want, out_tdata);
      end
    end
  end

  // receiver back-pressure, style changes each time the 8-bit rx_age counter wraps
  always @(posedge clk) begin
    rx_age <= rx_age + 8'd1;
    if (rx_age == 8'd0) rx_style <= $urandom_range(0, 2);
    if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      out_tready <= 1'b1;
      case (rx_style)
        1: if ($urandom_range(0, 3) == 0) rx_hold <= $urandom_range(1, 3);
        2: if ($urandom_range(0, 15) == 0) rx_hold <= $urandom_range(4, 24);
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
  end

  initial begin
    wait (quiet >= QUIET_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [15:0] meas;
    logic [15:0] sp;
    logic        cmd;
    ctl = '{mode: pid_pkg::MODE_POS, default: 0};
    hist = '{default: 0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < ROWS; r++) begin
      if (r == 0 || script[r].ph != script[r-1].ph) begin
        settle();
        dir_cfg(script[r].ph);
      end
      send(script[r].cmd, script[r].meas, script[r].sp, script[r].fixed, script[r].drv);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      load_cfg($urandom, pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        cmd = ($urandom_range(0, 31) == 0) ? CMD_CLR : CMD_STEP;
        if ($urandom_range(0, 9) < 7) begin
          // tracking near the setpoint keeps most errors small
          sp = $urandom;
          meas = sp + 16'($urandom_range(0, 64)) - 16'd32;
        end else begin
          sp = $urandom;
          meas = $urandom;
        end
        send(cmd, meas, sp, 1'b0, 32'h0);
      end
    end

    in_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (misses == 0 && drive_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
